// ----- design/cdll_pkg.sv -----
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared constants for the cursor doubly linked list: operation codes,
// status codes and default sizes.
// ----------------------------------------------------------------------------
package cdll_pkg;

  localparam int SLOTS_DEF       = 64;
  localparam int HANDLE_BITS_DEF = 32;

  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd1;
  localparam logic [OP_W-1:0] OP_PREV   = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

// ----- design/cdll_ram.sv -----
// ----------------------------------------------------------------------------
// cdll_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
module cdll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/cursor_doubly_linked_list_core.sv -----
// A result is held in the s1 register after the edge that accepts its item,
// then in the output register; a stalled output holds it in s1.
// Throughput: one item per cycle while in_stall is low. The list operation is
// combinational on link and payload RAM words prefetched at the next cursor slot.
// Reset (synchronous, rst_n low) empties the list: slot bitmap, head, tail,
// cursor and count go to zero. Link and payload RAMs are not cleared.
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_core
// Bounded doubly linked list of handles with a cursor: append, next,
// previous, remove at cursor and clear, one item per cycle while in_stall is low.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_core #(
  parameter int SLOTS       = cdll_pkg::SLOTS_DEF,
  parameter int HANDLE_BITS = cdll_pkg::HANDLE_BITS_DEF,
  parameter int IDX_W       = $clog2(SLOTS),
  parameter int CNT_W       = $clog2(SLOTS + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cdll_pkg::OP_W-1:0]  in_op,
  input  logic [HANDLE_BITS-1:0]     in_song_handle,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [HANDLE_BITS-1:0]     out_cursor_song,
  output logic                       out_cursor_valid,
  output logic [CNT_W-1:0]           out_entry_count,
  output logic [1:0]                 out_status
);

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  logic                  in_accept;
  logic                  s1_move;

  logic [SLOTS-1:0]      in_use_r, in_use_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [IDX_W-1:0]      cursor_r, cursor_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  cdll_pkg::status_t     s1_status_r, status;
  logic [CNT_W-1:0]      s1_count_r;

  logic                  out_valid_r;
  logic [HANDLE_BITS-1:0] out_song_r;
  logic                  out_cvalid_r;
  logic [CNT_W-1:0]      out_count_r;
  cdll_pkg::status_t     out_status_r;

  logic [SLOTS-1:0]      free_v, free_oh;
  logic [IDX_W-1:0]      free_idx;

  logic                  pay_we;
  logic [HANDLE_BITS-1:0] pay_rdata;
  logic                  nl_we, pl_we;
  logic [IDX_W-1:0]      nl_waddr, nl_wdata, nl_rdata;
  logic [IDX_W-1:0]      pl_waddr, pl_wdata, pl_rdata;

  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);

  // lowest free slot: isolate lowest set bit, then encode
  assign free_v  = ~in_use_r;
  assign free_oh = free_v & (~free_v + SLOTS'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cursor_nxt = cursor_r;
    count_nxt  = count_r;
    in_use_nxt = in_use_r;
    status     = cdll_pkg::ST_DONE;
    pay_we     = 1'b0;
    nl_we      = 1'b0;
    nl_waddr   = tail_r;
    nl_wdata   = free_idx;
    pl_we      = 1'b0;
    pl_waddr   = free_idx;
    pl_wdata   = tail_r;
    if (in_accept) begin
      unique case (in_op)
        cdll_pkg::OP_APPEND: begin
          if (count_r == SLOTS_CNT) begin
            status = cdll_pkg::ST_FULL;
          end else begin
            pay_we               = 1'b1;
            in_use_nxt[free_idx] = 1'b1;
            count_nxt            = count_r + ONE_CNT;
            if (count_r == '0) begin
              head_nxt   = free_idx;
              tail_nxt   = free_idx;
              cursor_nxt = free_idx;
            end else begin
              nl_we    = 1'b1;
              pl_we    = 1'b1;
              tail_nxt = free_idx;
            end
          end
        end
        cdll_pkg::OP_NEXT: begin
          if (count_r == '0) begin
            status = cdll_pkg::ST_EMPTY;
          end else begin
            cursor_nxt = (cursor_r == tail_r) ? head_r : nl_rdata;
          end
        end
        cdll_pkg::OP_PREV: begin
          if (count_r == '0) begin
            status = cdll_pkg::ST_EMPTY;
          end else if (cursor_r != head_r) begin
            cursor_nxt = pl_rdata;
          end
        end
        cdll_pkg::OP_REMOVE: begin
          if (count_r == '0) begin
            status = cdll_pkg::ST_EMPTY;
          end else if (count_r == ONE_CNT) begin
            in_use_nxt = '0;
            head_nxt   = '0;
            tail_nxt   = '0;
            cursor_nxt = '0;
            count_nxt  = '0;
          end else begin
            in_use_nxt[cursor_r] = 1'b0;
            count_nxt            = count_r - ONE_CNT;
            if (cursor_r == head_r) begin
              head_nxt   = nl_rdata;
              cursor_nxt = nl_rdata;
            end else if (cursor_r == tail_r) begin
              tail_nxt   = pl_rdata;
              cursor_nxt = pl_rdata;
            end else begin
              // unlink a middle entry
              nl_we      = 1'b1;
              nl_waddr   = pl_rdata;
              nl_wdata   = nl_rdata;
              pl_we      = 1'b1;
              pl_waddr   = nl_rdata;
              pl_wdata   = pl_rdata;
              cursor_nxt = nl_rdata;
            end
          end
        end
        cdll_pkg::OP_CLEAR: begin
          in_use_nxt = '0;
          head_nxt   = '0;
          tail_nxt   = '0;
          cursor_nxt = '0;
          count_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // read addresses follow the next cursor, so read data lines up with cursor_r
  cdll_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOTS)) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (free_idx),
    .wdata (in_song_handle),
    .raddr (cursor_nxt),
    .rdata (pay_rdata)
  );

  cdll_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (cursor_nxt),
    .rdata (nl_rdata)
  );

  cdll_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (cursor_nxt),
    .rdata (pl_rdata)
  );

  assign s1_valid_nxt = in_accept || (s1_valid_r && !s1_move);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r    <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cursor_r    <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_use_r   <= in_use_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      cursor_r   <= cursor_nxt;
      count_r    <= count_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status_r <= status;
      s1_count_r  <= count_nxt;
    end
    if (s1_move) begin
      out_cvalid_r <= (s1_count_r != '0);
      out_song_r   <= (s1_count_r != '0) ? pay_rdata : '0;
      out_count_r  <= s1_count_r;
      out_status_r <= s1_status_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cursor_song  = out_song_r;
  assign out_cursor_valid = out_cvalid_r;
  assign out_entry_count  = out_count_r;
  assign out_status       = out_status_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOTS_CNT)
    else $error("entry count above slot total");

  a_bitmap_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == 32'(count_r))
    else $error("slot bitmap disagrees with entry count");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (cursor_r == '0 && head_r == '0 && tail_r == '0))
    else $error("pointers not cleared on empty list");

  a_out_cvalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_cvalid_r == (out_count_r != '0)))
    else $error("cursor valid disagrees with count");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == cdll_pkg::OP_APPEND && count_r != SLOTS_CNT)
    |=> (count_r == $past(count_r) + ONE_CNT))
    else $error("append did not add an entry");
`endif

endmodule

// ----- test/tb_cursor_doubly_linked_list_core.sv -----
// ----------------------------------------------------------------------------
// tb_cursor_doubly_linked_list_core
// Self-checking bench for the cursor linked list. A queue of requests
// (directed corner cases, then random fill, grow, shrink and churn phases)
// feeds a falling-edge driver. A rising-edge monitor keeps its own model of
// the slot store and links, and predicts a result for every accepted item.
// It checks each returned result, field by field, against the oldest
// prediction. Random gaps on both sides, a long receiver hold-off and
// sender drain pauses exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_cursor_doubly_linked_list_core;

  localparam int SLOTS        = cdll_pkg::SLOTS_DEF;
  localparam int HB           = cdll_pkg::HANDLE_BITS_DEF;
  localparam int OP_W         = cdll_pkg::OP_W;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int CNT_W        = $clog2(SLOTS + 1);
  localparam int RANDOM_ITEMS = 1300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int TAIL_CYCLES  = 10;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [HB-1:0]   handle;
    int              gap;
    bit              drain;
  } play_req_t;

  typedef struct packed {
    logic [HB-1:0]      song;
    logic               valid;
    logic [CNT_W-1:0]   count;
    cdll_pkg::status_t  status;
  } play_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_op = cdll_pkg::OP_CLEAR;
  logic [HB-1:0]     in_song_handle = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [HB-1:0]     out_cursor_song;
  logic              out_cursor_valid;
  logic [CNT_W-1:0]  out_entry_count;
  logic [1:0]        out_status;

  cursor_doubly_linked_list_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_song_handle   (in_song_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cursor_song  (out_cursor_song),
    .out_cursor_valid (out_cursor_valid),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

  always #4 clk = ~clk;

  play_req_t pending_reqs[$];
  play_res_t expected_res[$];
  bit        gapless;
  bit        in_taken;
  int        errors, items_in, results_out, idle_cycles;
  int        full_refusals, empty_ignores, peak_len;

  // list model
  logic [HB-1:0]    song_mem [SLOTS];
  logic [IDX_W-1:0] fwd_link [SLOTS];
  logic [IDX_W-1:0] bwd_link [SLOTS];
  logic [SLOTS-1:0] slot_busy;
  logic [IDX_W-1:0] head_at, tail_at, cur_at;
  int               list_len;

  function automatic void empty_playlist();
    slot_busy = '0;
    head_at   = '0;
    tail_at   = '0;
    cur_at    = '0;
    list_len  = 0;
  endfunction

  function automatic play_res_t playlist_step(input logic [OP_W-1:0] op,
                                              input logic [HB-1:0] h);
    play_res_t        res;
    logic [IDX_W-1:0] s, nx, pv;
    res.status = cdll_pkg::ST_DONE;
    case (op)
      cdll_pkg::OP_APPEND: begin
        if (list_len >= SLOTS) begin
          res.status = cdll_pkg::ST_FULL;
        end else begin
          s = '0;
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_busy[i]) s = IDX_W'(i);
          slot_busy[s] = 1'b1;
          song_mem[s]  = h;
          fwd_link[s]  = '0;
          bwd_link[s]  = '0;
          if (list_len == 0) begin
            head_at = s;
            tail_at = s;
            cur_at  = s;
          end else begin
            fwd_link[tail_at] = s;
            bwd_link[s]       = tail_at;
            tail_at           = s;
          end
          list_len++;
        end
      end
      cdll_pkg::OP_NEXT, cdll_pkg::OP_PREV, cdll_pkg::OP_REMOVE: begin
        if (list_len == 0) begin
          res.status = cdll_pkg::ST_EMPTY;
        end else if (op == cdll_pkg::OP_NEXT) begin
          cur_at = (cur_at == tail_at) ? head_at : fwd_link[cur_at];
        end else if (op == cdll_pkg::OP_PREV) begin
          if (cur_at != head_at) cur_at = bwd_link[cur_at];
        end else if (list_len == 1) begin
          empty_playlist();
        end else begin
          s  = cur_at;
          nx = fwd_link[s];
          pv = bwd_link[s];
          if (s == head_at) begin
            head_at      = nx;
            bwd_link[nx] = '0;
            cur_at       = nx;
          end else if (s == tail_at) begin
            tail_at      = pv;
            fwd_link[pv] = '0;
            cur_at       = pv;
          end else begin
            fwd_link[pv] = nx;
            bwd_link[nx] = pv;
            cur_at       = nx;
          end
          slot_busy[s] = 1'b0;
          list_len--;
        end
      end
      cdll_pkg::OP_CLEAR: empty_playlist();
      default: ;
    endcase
    res.valid = (list_len > 0);
    res.song  = (list_len > 0) ? song_mem[cur_at] : '0;
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [HB-1:0] got,
                                 input logic [HB-1:0] want);
    $display("ERROR @%0t result %0d: %s got %h want %h", $realtime, results_out, what,
             got, want);
    errors++;
  endtask

  task automatic queue_req(input logic [OP_W-1:0] op, input logic [HB-1:0] h,
                           input bit drain);
    play_req_t req;
    int        r;
    r         = $urandom_range(0, 99);
    req.op    = op;
    req.handle = h;
    req.drain = drain;
    if (gapless || r < 60) req.gap = 0;
    else if (r < 88)       req.gap = $urandom_range(1, 3);
    else if (r < 97)       req.gap = $urandom_range(4, 12);
    else                   req.gap = $urandom_range(20, 60);
    pending_reqs.push_back(req);
  endtask

  // driver
  int        gap_left;
  play_req_t offer;

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_taken)) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_reqs.size() == 0 ||
                 (pending_reqs[0].drain && expected_res.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      offer = pending_reqs.pop_front();
      gap_left = offer.gap;
      in_valid <= 1'b1;
      in_op <= offer.op;
      in_song_handle <= offer.handle;
    end
  end

  // receiver
  int hold_left, pause_left, flow_left;
  int hold_at = 500;

  always @(negedge clk) begin : receiver_b
    int r;
    if (hold_left == 0 && items_in >= hold_at) begin
      hold_left = LONG_HOLD;
      hold_at   = hold_at + 700;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (pause_left > 0) begin
      out_stall <= 1'b1;
      pause_left--;
    end else if (flow_left > 0) begin
      out_stall <= 1'b0;
      flow_left--;
    end else begin
      out_stall <= 1'b0;
      r = $urandom_range(0, 99);
      flow_left = (r < 15) ? $urandom_range(20, 80) : $urandom_range(0, 5);
      r = $urandom_range(0, 99);
      if (r < 80)      pause_left = $urandom_range(1, 2);
      else if (r < 95) pause_left = $urandom_range(3, 8);
      else             pause_left = $urandom_range(15, 40);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor_b
    play_res_t pred, want;
    bit        moved;
    in_taken = 1'b0;
    moved    = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        moved    = 1'b1;
        pred     = playlist_step(in_op, in_song_handle);
        expected_res.push_back(pred);
        items_in++;
        if (pred.status == cdll_pkg::ST_FULL)  full_refusals++;
        if (pred.status == cdll_pkg::ST_EMPTY) empty_ignores++;
        if (list_len > peak_len)               peak_len = list_len;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_res.size() == 0) begin
          report_mismatch("result with nothing pending, song", out_cursor_song, '0);
        end else begin
          want = expected_res.pop_front();
          if (out_cursor_song !== want.song)
            report_mismatch("cursor_song", out_cursor_song, want.song);
          if (out_cursor_valid !== want.valid)
            report_mismatch("cursor_valid", HB'(out_cursor_valid), HB'(want.valid));
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", HB'(out_entry_count), HB'(want.count));
          if (out_status !== want.status)
            report_mismatch("status", HB'(out_status), HB'(want.status));
        end
        results_out++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, expected_res.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus_b
    int                random_reqs, mode, len, r;
    logic [OP_W-1:0]   op;
    bit                drain;
    empty_playlist();
    // directed corner cases
    gapless = 1'b0;
    queue_req(cdll_pkg::OP_NEXT,   $urandom, 1'b0);
    queue_req(cdll_pkg::OP_PREV,   $urandom, 1'b0);
    queue_req(cdll_pkg::OP_REMOVE, $urandom, 1'b0);
    queue_req(cdll_pkg::OP_CLEAR,  $urandom, 1'b0);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
      queue_req(OP_W'(c), $urandom, 1'b0);
    queue_req(cdll_pkg::OP_APPEND, '0, 1'b0);
    queue_req(cdll_pkg::OP_APPEND, '1, 1'b0);
    queue_req(cdll_pkg::OP_APPEND, 32'hA5A5_A5A5, 1'b0);
    queue_req(cdll_pkg::OP_PREV,   '0, 1'b0);
    queue_req(cdll_pkg::OP_NEXT,   '0, 1'b0);
    queue_req(cdll_pkg::OP_NEXT,   '0, 1'b0);
    queue_req(cdll_pkg::OP_NEXT,   '0, 1'b0);
    queue_req(cdll_pkg::OP_NEXT,   '0, 1'b0);
    queue_req(cdll_pkg::OP_REMOVE, '0, 1'b0);
    queue_req(cdll_pkg::OP_REMOVE, '0, 1'b0);
    queue_req(cdll_pkg::OP_APPEND, 32'h5A5A_5A5A, 1'b0);
    queue_req(cdll_pkg::OP_REMOVE, '0, 1'b0);
    queue_req(cdll_pkg::OP_REMOVE, '0, 1'b0);
    queue_req(cdll_pkg::OP_APPEND, 32'h1234_5678, 1'b0);
    queue_req(cdll_pkg::OP_APPEND, 32'h8765_4321, 1'b0);
    queue_req(OP_SPARE_HI, '1, 1'b0);
    queue_req(cdll_pkg::OP_CLEAR,  '1, 1'b0);
    // random phases: fill, grow, shrink, churn
    random_reqs = 0;
    mode        = 0;
    while (random_reqs < RANDOM_ITEMS) begin
      gapless = ($urandom_range(0, 3) == 0);
      drain   = (random_reqs == 0) || ($urandom_range(0, 2) == 0);
      len     = (mode == 0) ? 100 : $urandom_range(20, 120);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       op = (r < 85) ? cdll_pkg::OP_APPEND :
                        (r < 90) ? cdll_pkg::OP_NEXT :
                        (r < 94) ? cdll_pkg::OP_PREV :
                        (r < 97) ? cdll_pkg::OP_REMOVE : OP_SPARE_LO;
          1:       op = (r < 55) ? cdll_pkg::OP_APPEND :
                        (r < 70) ? cdll_pkg::OP_NEXT :
                        (r < 82) ? cdll_pkg::OP_PREV :
                        (r < 94) ? cdll_pkg::OP_REMOVE :
                        (r < 95) ? cdll_pkg::OP_CLEAR : OP_SPARE_LO;
          2:       op = (r < 10) ? cdll_pkg::OP_APPEND :
                        (r < 25) ? cdll_pkg::OP_NEXT :
                        (r < 38) ? cdll_pkg::OP_PREV :
                        (r < 93) ? cdll_pkg::OP_REMOVE :
                        (r < 95) ? cdll_pkg::OP_CLEAR : OP_SPARE_LO;
          default: op = (r < 30) ? cdll_pkg::OP_APPEND :
                        (r < 52) ? cdll_pkg::OP_NEXT :
                        (r < 72) ? cdll_pkg::OP_PREV :
                        (r < 95) ? cdll_pkg::OP_REMOVE :
                        (r < 97) ? cdll_pkg::OP_CLEAR : OP_SPARE_LO;
        endcase
        if (op == OP_SPARE_LO) op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        queue_req(op, $urandom, drain && k == 0);
        if (op <= cdll_pkg::OP_CLEAR) random_reqs++;
      end
      mode = $urandom_range(0, 3);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid) @(negedge clk);
    while (expected_res.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Ran %0d items, checked %0d results; peak length %0d of %0d slots",
             items_in, results_out, peak_len, SLOTS);
    $display("Appends refused when full: %0d, operations on an empty list: %0d",
             full_refusals, empty_ignores);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cdll_pkg.sv
design/cdll_ram.sv
design/cursor_doubly_linked_list_core.sv
test/tb_cursor_doubly_linked_list_core.sv
